FILE: sv/cdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque package
// Shared word type, default depth, and operation and status codes.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned WordWidth    = 32;

  typedef logic signed [WordWidth-1:0] word_t;

  localparam word_t NoneWord = '1;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_PEEK       = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage
`default_nettype wire

FILE: sv/cdq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int unsigned DEPTH = cdq_pkg::DefaultDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire cdq_pkg::word_t wdata_i,
  input  wire logic           re_i,
  input  wire logic [AW-1:0]  raddr_i,
  output cdq_pkg::word_t      rdata_o
);
  import cdq_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: sv/circular_deque_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Circular deque unit
// Double-ended queue of signed words in a ring memory with cached end words.
// ----------------------------------------------------------------------------
// Sequence: an accepted word goes from the idle state to the completion state,
// through the ring memory read state first for a pop that leaves the deque
// non-empty; its result is offered once the output register is free. No new word
// is taken before then, but the next one is taken while that result waits there.
// Reset: pointers and count clear to an empty deque; memory contents stay.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::DefaultDepth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            mode_i,
  input  wire cdq_pkg::word_t        push_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output cdq_pkg::word_t             popped_value_o,
  output logic [1:0]                 status_o,
  output cdq_pkg::word_t             front_value_o,
  output cdq_pkg::word_t             rear_value_o,
  output logic                       is_empty_o,
  output logic                       is_full_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? LastIdx : i - AW'(1);
  endfunction

  state_e        state_q;
  logic [AW-1:0] head_q, tail_q;
  logic [CW-1:0] count_q;
  word_t         front_q, rear_q;
  logic          rd_front_q;
  word_t         popped_q;
  status_e       status_q;
  logic          out_valid_q;
  word_t         out_popped_q, out_front_q, out_rear_q;
  status_e       out_status_q;
  logic          out_empty_q, out_full_q;

  logic          accept;
  logic          is_empty, is_full;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  word_t         rdata;
  logic          out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == FullCnt);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = tail_q;
    raddr = ring_next(ring_next(head_q));
    if (accept) begin
      case (mode_i)
        MODE_PUSH_FRONT: begin
          we    = !is_full;
          waddr = ring_prev(head_q);
        end
        MODE_PUSH_REAR: begin
          we    = !is_full;
          waddr = tail_q;
        end
        MODE_POP_FRONT: begin
          re    = (count_q > CW'(1));
          raddr = ring_next(head_q);
        end
        MODE_POP_REAR: begin
          re    = (count_q > CW'(1));
          raddr = ring_prev(ring_prev(tail_q));
        end
        default: begin
          re = 1'b0;
        end
      endcase
    end
  end

  cdq_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(push_value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      front_q      <= '0;
      rear_q       <= '0;
      rd_front_q   <= 1'b0;
      popped_q     <= NoneWord;
      status_q     <= STATUS_DONE;
      out_valid_q  <= 1'b0;
      out_popped_q <= NoneWord;
      out_front_q  <= NoneWord;
      out_rear_q   <= NoneWord;
      out_status_q <= STATUS_DONE;
      out_empty_q  <= 1'b1;
      out_full_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            case (mode_i)
              MODE_PUSH_FRONT: begin
                popped_q <= NoneWord;
                state_q  <= ST_DONE;
                if (is_full) begin
                  status_q <= STATUS_FULL;
                end else begin
                  status_q <= STATUS_DONE;
                  head_q   <= ring_prev(head_q);
                  count_q  <= count_q + CW'(1);
                  front_q  <= push_value_i;
                  if (is_empty) begin
                    rear_q <= push_value_i;
                  end
                end
              end
              MODE_PUSH_REAR: begin
                popped_q <= NoneWord;
                state_q  <= ST_DONE;
                if (is_full) begin
                  status_q <= STATUS_FULL;
                end else begin
                  status_q <= STATUS_DONE;
                  tail_q   <= ring_next(tail_q);
                  count_q  <= count_q + CW'(1);
                  rear_q   <= push_value_i;
                  if (is_empty) begin
                    front_q <= push_value_i;
                  end
                end
              end
              MODE_POP_FRONT: begin
                if (is_empty) begin
                  popped_q <= NoneWord;
                  status_q <= STATUS_EMPTY;
                  state_q  <= ST_DONE;
                end else begin
                  popped_q   <= front_q;
                  status_q   <= STATUS_DONE;
                  head_q     <= ring_next(head_q);
                  count_q    <= count_q - CW'(1);
                  rd_front_q <= 1'b1;
                  state_q    <= (count_q > CW'(1)) ? ST_READ : ST_DONE;
                end
              end
              MODE_POP_REAR: begin
                if (is_empty) begin
                  popped_q <= NoneWord;
                  status_q <= STATUS_EMPTY;
                  state_q  <= ST_DONE;
                end else begin
                  popped_q   <= rear_q;
                  status_q   <= STATUS_DONE;
                  tail_q     <= ring_prev(tail_q);
                  count_q    <= count_q - CW'(1);
                  rd_front_q <= 1'b0;
                  state_q    <= (count_q > CW'(1)) ? ST_READ : ST_DONE;
                end
              end
              default: begin
                popped_q <= NoneWord;
                status_q <= STATUS_DONE;
                state_q  <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          if (rd_front_q) begin
            front_q <= rdata;
          end else begin
            rear_q <= rdata;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_popped_q <= popped_q;
            out_status_q <= status_q;
            out_front_q  <= is_empty ? NoneWord : front_q;
            out_rear_q   <= is_empty ? NoneWord : rear_q;
            out_empty_q  <= is_empty;
            out_full_q   <= is_full;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_popped_q;
  assign status_o       = out_status_q;
  assign front_value_o  = out_front_q;
  assign rear_value_o   = out_rear_q;
  assign is_empty_o     = out_empty_q;
  assign is_full_o      = out_full_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("Occupancy exceeds the ring depth.");

  a_ends_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> head_q == tail_q)
    else $error("Head and tail disagree for an empty or full ring.");

  a_read_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> $past(accept))
    else $error("Memory read stage entered without an accepted word.");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("Ring memory written and read in the same cycle.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("Result presented outside the completion state.");
`endif

endmodule
`default_nettype wire
